@@ design/wss_pkg.sv @@
// wss_pkg: shared types, codes, widths and reset values of the wakeup sweep sequencer
// no dependencies; compile first
`default_nettype none

package wss_pkg;

	localparam int unsigned TIMER_W    = 18;
	localparam int unsigned DELAY_W    = 16;
	localparam int unsigned CNT_W      = 8;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CFG_IDX_W  = 3;

	localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

	// trigger bit positions
	localparam int unsigned TRIG_NM3  = 0;
	localparam int unsigned TRIG_WUP  = 1;
	localparam int unsigned TRIG_BOTH = 2;

	typedef logic [2:0] trig_t;

	typedef enum logic [1:0] {
		MODE_OFF   = 2'd0,
		MODE_BURST = 2'd1,
		MODE_RELAY = 2'd2,
		MODE_BOTH  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_ACTION = 2'd1,
		PH_WAIT   = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE     = 2'd0,
		ST_ONGOING  = 2'd1,
		ST_FINISHED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		RLY_NONE = 2'd0,
		RLY_ON   = 2'd1,
		RLY_OFF  = 2'd2
	} relay_cmd_t;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BURST_PERIOD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BURST_FRAMES = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELAY_HOLD   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POST_WAIT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SWEEP_START  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SWEEP_END    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SWEEP_STEP   = 3'd6;

	// register reset values
	localparam logic [CNT_W-1:0]   RST_BURST_PERIOD = 8'd5;
	localparam logic [CNT_W-1:0]   RST_BURST_FRAMES = 8'd20;
	localparam logic [DELAY_W-1:0] RST_RELAY_HOLD   = 16'd500;
	localparam logic [DELAY_W-1:0] RST_POST_WAIT    = 16'd1000;
	localparam logic [DELAY_W-1:0] RST_SWEEP_START  = 16'd0;
	localparam logic [DELAY_W-1:0] RST_SWEEP_END    = 16'd3740;
	localparam logic [CNT_W-1:0]   RST_SWEEP_STEP   = 8'd1;

	typedef struct packed {
		logic [CNT_W-1:0]   burst_period;
		logic [CNT_W-1:0]   burst_frames;
		logic [DELAY_W-1:0] relay_hold;
		logic [DELAY_W-1:0] post_wait;
		logic [DELAY_W-1:0] sweep_start;
		logic [DELAY_W-1:0] sweep_end;
		logic [CNT_W-1:0]   sweep_step;
	} cfg_t;

	typedef struct packed {
		logic               send_frame;
		logic [1:0]         relay_cmd;
		logic               relay_state;
		logic [1:0]         status_nm3;
		logic [1:0]         status_wup;
		logic [1:0]         status_both;
		logic [DELAY_W-1:0] current_delay;
		logic [1:0]         phase_code;
	} res_t;

endpackage

`default_nettype wire

@@ design/wss_if.sv @@
// wss_in_if / wss_out_if: valid-ready channels for trigger ticks and step results
// no dependencies
`default_nettype none

interface wss_in_if;
	logic valid;
	logic ready;
	logic trig_nm3;
	logic trig_wup;
	logic trig_both;

	modport source(output valid, trig_nm3, trig_wup, trig_both, input ready);
	modport sink(input valid, trig_nm3, trig_wup, trig_both, output ready);
endinterface

interface wss_out_if;
	logic        valid;
	logic        ready;
	logic        send_frame;
	logic [1:0]  relay_cmd;
	logic        relay_state;
	logic [1:0]  status_nm3;
	logic [1:0]  status_wup;
	logic [1:0]  status_both;
	logic [15:0] current_delay;
	logic [1:0]  phase_code;

	modport source(output valid, send_frame, relay_cmd, relay_state, status_nm3, status_wup,
		status_both, current_delay, phase_code, input ready);
	modport sink(input valid, send_frame, relay_cmd, relay_state, status_nm3, status_wup,
		status_both, current_delay, phase_code, output ready);
endinterface

`default_nettype wire

@@ design/wakeup_sweep_sequencer_unit.sv @@
// wakeup_sweep_sequencer_unit: top level, input register, result register and handshakes
// depends on wss_pkg, wss_if, wss_cfg, wss_step
`default_nettype none

// Wakeup sweep sequencer. Each input beat is one millisecond tick carrying the
// three start-trigger levels; each tick gives exactly one result beat with the
// frame strobe, relay command and state, the three per-mode statuses, the
// present sweep delay and the phase. A rising trigger edge while idle starts a
// test (combined mode first, then relay-only, then burst-only); dropping the
// running mode's own trigger aborts it. The block takes one beat per clock
// while the result register is not stalled: a tick is captured in an input
// register, the whole tick update runs as combinational logic against the
// sequencer state, and the result lands in an output register, from which it
// is offered. A stalled result register holds off one more input beat and
// then backpressure reaches the input. Configuration registers are written
// through the plain write port and should only change while no beats are in
// flight; there is no read-back.

module wakeup_sweep_sequencer_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	wss_in_if.sink                         in_ch,
	wss_out_if.source                      out_ch,
	input  logic                           cfg_wr_en,
	input  logic [wss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wss_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
	import wss_pkg::*;

	cfg_t  cfg;
	res_t  res;

	// input register stage
	logic  valid_s1;
	trig_t trig_s1;

	// result register
	logic  out_valid_q;
	res_t  out_res_q;

	logic  advance;
	logic  in_take;

	// a tick moves into the result register when that register is free or draining
	assign advance = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;
	assign in_take = in_ch.valid && in_ch.ready;

	wss_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_wr_en),
		.index   (cfg_index),
		.wr_data (cfg_wr_data),
		.cfg     (cfg)
	);

	wss_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step_en (advance),
		.trig    (trig_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_take) begin
			trig_s1[TRIG_NM3]  <= in_ch.trig_nm3;
			trig_s1[TRIG_WUP]  <= in_ch.trig_wup;
			trig_s1[TRIG_BOTH] <= in_ch.trig_both;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_res_q <= res;
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.send_frame    = out_res_q.send_frame;
	assign out_ch.relay_cmd     = out_res_q.relay_cmd;
	assign out_ch.relay_state   = out_res_q.relay_state;
	assign out_ch.status_nm3    = out_res_q.status_nm3;
	assign out_ch.status_wup    = out_res_q.status_wup;
	assign out_ch.status_both   = out_res_q.status_both;
	assign out_ch.current_delay = out_res_q.current_delay;
	assign out_ch.phase_code    = out_res_q.phase_code;

endmodule

`default_nettype wire

@@ design/wss_cfg.sv @@
// wss_cfg: configuration register bank with write-only access
// depends on wss_pkg
`default_nettype none

module wss_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [wss_pkg::CFG_IDX_W-1:0]      index,
	input  logic [wss_pkg::CFG_DATA_W-1:0]     wr_data,
	output wss_pkg::cfg_t                      cfg
);
	import wss_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.burst_period <= RST_BURST_PERIOD;
			cfg_q.burst_frames <= RST_BURST_FRAMES;
			cfg_q.relay_hold   <= RST_RELAY_HOLD;
			cfg_q.post_wait    <= RST_POST_WAIT;
			cfg_q.sweep_start  <= RST_SWEEP_START;
			cfg_q.sweep_end    <= RST_SWEEP_END;
			cfg_q.sweep_step   <= RST_SWEEP_STEP;
		end else if (wr_en) begin
			case (index)
				REG_BURST_PERIOD: cfg_q.burst_period <= wr_data[CNT_W-1:0];
				REG_BURST_FRAMES: cfg_q.burst_frames <= wr_data[CNT_W-1:0];
				REG_RELAY_HOLD:   cfg_q.relay_hold   <= wr_data[DELAY_W-1:0];
				REG_POST_WAIT:    cfg_q.post_wait    <= wr_data[DELAY_W-1:0];
				REG_SWEEP_START:  cfg_q.sweep_start  <= wr_data[DELAY_W-1:0];
				REG_SWEEP_END:    cfg_q.sweep_end    <= wr_data[DELAY_W-1:0];
				REG_SWEEP_STEP:   cfg_q.sweep_step   <= wr_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ design/wss_step.sv @@
// wss_step: sequencer state registers and the one-tick next-state logic
// depends on wss_pkg
`default_nettype none

module wss_step (
	input  logic           clk,
	input  logic           arst_n,
	input  wss_pkg::cfg_t  cfg,
	input  logic           step_en,
	input  wss_pkg::trig_t trig,
	output wss_pkg::res_t  res
);
	import wss_pkg::*;

	typedef struct packed {
		mode_t              mode;
		phase_t             phase;
		logic [DELAY_W-1:0] ed;
		logic [TIMER_W-1:0] pt;
		logic [CNT_W-1:0]   fs;
		logic [TIMER_W-1:0] nft;
		logic               br;
		logic               rh;
		trig_t              prev;
		status_t            s_nm3;
		status_t            s_wup;
		status_t            s_both;
	} state_t;

	typedef struct packed {
		state_t st;
		logic   on;
		logic   off;
		logic   fo;
	} work_t;

	function automatic logic uses_nm3(mode_t m);
		return (m == MODE_BURST) || (m == MODE_BOTH);
	endfunction

	function automatic logic uses_wup(mode_t m);
		return (m == MODE_RELAY) || (m == MODE_BOTH);
	endfunction

	function automatic logic own_trig(trig_t t, mode_t m);
		logic r;
		case (m)
			MODE_BURST: r = t[TRIG_NM3];
			MODE_RELAY: r = t[TRIG_WUP];
			default:    r = t[TRIG_BOTH];
		endcase
		return r;
	endfunction

	function automatic work_t begin_action(work_t w);
		w.st.phase = PH_ACTION;
		w.st.pt    = '0;
		w.st.rh    = 1'b0;
		w.st.br    = 1'b0;
		w.st.nft   = '0;
		w.st.fs    = '0;
		if (uses_wup(w.st.mode)) begin
			w.on    = 1'b1;
			w.st.rh = 1'b1;
		end
		if (uses_nm3(w.st.mode))
			w.st.br = 1'b1;
		return w;
	endfunction

	function automatic work_t begin_run(work_t w, mode_t m, logic [DELAY_W-1:0] start);
		w.st.mode   = m;
		w.st.ed     = start;
		w.st.s_nm3  = (m == MODE_BURST) ? ST_ONGOING : ST_IDLE;
		w.st.s_wup  = (m == MODE_RELAY) ? ST_ONGOING : ST_IDLE;
		w.st.s_both = (m == MODE_BOTH)  ? ST_ONGOING : ST_IDLE;
		return begin_action(w);
	endfunction

	function automatic work_t stop_run(work_t w, logic fin, logic [DELAY_W-1:0] start);
		mode_t old;
		old = w.st.mode;
		if (w.st.rh)
			w.off = 1'b1;
		w.st.rh     = 1'b0;
		w.st.br     = 1'b0;
		w.st.nft    = '0;
		w.st.fs     = '0;
		w.st.pt     = '0;
		w.st.mode   = MODE_OFF;
		w.st.phase  = PH_IDLE;
		w.st.ed     = start;
		w.st.s_nm3  = ST_IDLE;
		w.st.s_wup  = ST_IDLE;
		w.st.s_both = ST_IDLE;
		if (fin) begin
			case (old)
				MODE_BURST: w.st.s_nm3  = ST_FINISHED;
				MODE_RELAY: w.st.s_wup  = ST_FINISHED;
				MODE_BOTH:  w.st.s_both = ST_FINISHED;
				default: ;
			endcase
		end
		return w;
	endfunction

	state_t             st_q;
	work_t              w;
	trig_t              rise;
	logic               active;
	logic [CNT_W-1:0]   per;
	logic [TIMER_W:0]   nft_sum;
	logic [DELAY_W:0]   total;
	logic [DELAY_W:0]   ed_sum;

	always_comb begin
		w.st  = st_q;
		w.on  = 1'b0;
		w.off = 1'b0;
		w.fo  = 1'b0;
		rise  = trig & ~st_q.prev;
		per   = (cfg.burst_period == '0) ? CNT_W'(1) : cfg.burst_period;
		nft_sum = '0;
		ed_sum  = '0;

		// start or abort
		if (w.st.mode == MODE_OFF) begin
			if (rise[TRIG_BOTH])
				w = begin_run(w, MODE_BOTH, cfg.sweep_start);
			else if (rise[TRIG_WUP])
				w = begin_run(w, MODE_RELAY, cfg.sweep_start);
			else if (rise[TRIG_NM3])
				w = begin_run(w, MODE_BURST, cfg.sweep_start);
		end else if (!own_trig(trig, w.st.mode)) begin
			w = stop_run(w, 1'b0, cfg.sweep_start);
		end

		active = (w.st.mode != MODE_OFF);
		total  = {1'b0, cfg.post_wait} + {1'b0, w.st.ed};

		if (active) begin
			case (w.st.phase)
				PH_ACTION: begin
					if (uses_nm3(w.st.mode) && w.st.br) begin
						if (w.st.fs >= cfg.burst_frames) begin
							w.st.br = 1'b0;
						end else if (w.st.pt >= w.st.nft) begin
							w.fo    = 1'b1;
							w.st.fs = w.st.fs + CNT_W'(1);
							nft_sum = {1'b0, w.st.nft} + (TIMER_W+1)'(per);
							w.st.nft = nft_sum[TIMER_W] ? TIMER_MAX : nft_sum[TIMER_W-1:0];
							if (w.st.fs >= cfg.burst_frames)
								w.st.br = 1'b0;
						end
					end
					if (uses_wup(w.st.mode) && w.st.rh
						&& (w.st.pt >= TIMER_W'(cfg.relay_hold))) begin
						w.off   = 1'b1;
						w.st.rh = 1'b0;
					end
					if ((!uses_wup(w.st.mode) || !w.st.rh)
						&& (!uses_nm3(w.st.mode) || !w.st.br)) begin
						w.st.phase = PH_WAIT;
						w.st.pt    = '0;
					end
				end
				PH_WAIT: begin
					if (w.st.pt >= TIMER_W'(total)) begin
						if (w.st.ed >= cfg.sweep_end) begin
							w = stop_run(w, 1'b1, cfg.sweep_start);
						end else begin
							ed_sum  = {1'b0, w.st.ed} + (DELAY_W+1)'(cfg.sweep_step);
							w.st.ed = ed_sum[DELAY_W] ? {DELAY_W{1'b1}} : ed_sum[DELAY_W-1:0];
							w = begin_action(w);
						end
					end
				end
				default: ;
			endcase
			// timer still advances on the finishing tick
			if (w.st.pt != TIMER_MAX)
				w.st.pt = w.st.pt + TIMER_W'(1);
		end

		w.st.prev = trig;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (step_en) begin
			st_q <= w.st;
		end
	end

	always_comb begin
		res.send_frame    = w.fo;
		if (w.on && !w.off)
			res.relay_cmd = RLY_ON;
		else if (w.off && !w.on)
			res.relay_cmd = RLY_OFF;
		else
			res.relay_cmd = RLY_NONE;
		res.relay_state   = w.st.rh;
		res.status_nm3    = w.st.s_nm3;
		res.status_wup    = w.st.s_wup;
		res.status_both   = w.st.s_both;
		res.current_delay = w.st.ed;
		res.phase_code    = w.st.phase;
	end

endmodule

`default_nettype wire

@@ dv/tb_wakeup_sweep_sequencer_unit.sv @@
`timescale 1ns / 100ps
// tb_wakeup_sweep_sequencer_unit: self-checking bench for the wakeup sweep sequencer,
// driving trigger ticks and comparing every result beat against a behavioral copy of the block
// depends on wss_pkg, wss_if and the wakeup_sweep_sequencer_unit rtl

module tb_wakeup_sweep_sequencer_unit;
	import wss_pkg::*;

	localparam int unsigned LONG_STALL = 150;
	localparam int unsigned MAX_PRINTS = 200;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wr_data;

	wss_in_if  in_ch();
	wss_out_if out_ch();

	wakeup_sweep_sequencer_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wr_data(cfg_wr_data)
	);

	// ------------------------------------------------------------------
	// bench state shared between the stimulus and the checker
	// ------------------------------------------------------------------
	int unsigned src_idle_pct;   // chance per cycle that the tick source holds back
	int unsigned snk_idle_pct;   // chance per cycle that the result sink drops ready
	int unsigned hold_requests;  // bumped to ask the sink for one long stall
	int unsigned ticks_sent;
	int unsigned mismatch_cnt;
	res_t        tick_results_q[$];

	// ------------------------------------------------------------------
	// behavioral copy of the sequencer: registers and state at rtl widths
	// ------------------------------------------------------------------
	cfg_t              m_cfg;
	mode_t             m_mode;
	phase_t            m_phase;
	logic [DELAY_W-1:0] m_delay;
	logic [TIMER_W-1:0] m_timer;
	logic [TIMER_W-1:0] m_next_frame;
	logic [CNT_W-1:0]   m_frames;
	logic              m_burst;
	logic              m_relay;
	trig_t             m_prev;
	status_t           m_status[3];   // indexed by trigger bit position
	logic              f_on, f_off, f_frame;

	// trigger bit (and status slot) that belongs to a running mode
	function automatic int unsigned trig_index(mode_t mode);
		case (mode)
			MODE_BURST: return TRIG_NM3;
			MODE_RELAY: return TRIG_WUP;
			default:    return TRIG_BOTH;
		endcase
	endfunction

	function automatic bit uses_burst();
		return m_mode == MODE_BURST || m_mode == MODE_BOTH;
	endfunction

	function automatic bit uses_relay();
		return m_mode == MODE_RELAY || m_mode == MODE_BOTH;
	endfunction

	// fresh action phase: relay on for relay modes, burst armed for burst modes
	function automatic void enter_action();
		m_phase      = PH_ACTION;
		m_timer      = '0;
		m_relay      = 1'b0;
		m_burst      = 1'b0;
		m_next_frame = '0;
		m_frames     = '0;
		if (uses_relay()) begin
			f_on    = 1'b1;
			m_relay = 1'b1;
		end
		if (uses_burst())
			m_burst = 1'b1;
	endfunction

	function automatic void launch_run(mode_t mode);
		m_mode  = mode;
		m_delay = m_cfg.sweep_start;
		foreach (m_status[i])
			m_status[i] = ST_IDLE;
		m_status[trig_index(mode)] = ST_ONGOING;
		enter_action();
	endfunction

	// abort or finish: relay dropped if held, sweep rewound, only a finish leaves a mark
	function automatic void end_test(bit finished);
		mode_t old_mode;
		old_mode = m_mode;
		if (m_relay)
			f_off = 1'b1;
		m_relay      = 1'b0;
		m_burst      = 1'b0;
		m_next_frame = '0;
		m_frames     = '0;
		m_timer      = '0;
		m_mode       = MODE_OFF;
		m_phase      = PH_IDLE;
		m_delay      = m_cfg.sweep_start;
		foreach (m_status[i])
			m_status[i] = ST_IDLE;
		if (finished)
			m_status[trig_index(old_mode)] = ST_FINISHED;
	endfunction

	// one millisecond tick: returns the result beat the block owes for it
	function automatic res_t sequencer_tick(trig_t lvl);
		trig_t       rise;
		int unsigned per, nf, wait_len, grown;
		res_t        r;
		rise    = lvl & ~m_prev;
		f_on    = 1'b0;
		f_off   = 1'b0;
		f_frame = 1'b0;

		// start priority: combined, relay only, burst only
		if (m_mode == MODE_OFF) begin
			if (rise[TRIG_BOTH])
				launch_run(MODE_BOTH);
			else if (rise[TRIG_WUP])
				launch_run(MODE_RELAY);
			else if (rise[TRIG_NM3])
				launch_run(MODE_BURST);
		end else if (!lvl[trig_index(m_mode)]) begin
			end_test(1'b0);
		end

		if (m_mode != MODE_OFF) begin
			if (m_phase == PH_ACTION) begin
				if (uses_burst() && m_burst) begin
					// a zero period still spaces frames one tick apart
					per = (m_cfg.burst_period == '0) ? 32'd1 : 32'(m_cfg.burst_period);
					if (m_frames >= m_cfg.burst_frames) begin
						m_burst = 1'b0;
					end else if (m_timer >= m_next_frame) begin
						f_frame      = 1'b1;
						m_frames     = m_frames + CNT_W'(1);
						nf           = 32'(m_next_frame) + per;
						m_next_frame = (nf > 32'(TIMER_MAX)) ? TIMER_MAX : nf[TIMER_W-1:0];
						if (m_frames >= m_cfg.burst_frames)
							m_burst = 1'b0;
					end
				end
				if (uses_relay() && m_relay && m_timer >= TIMER_W'(m_cfg.relay_hold)) begin
					f_off   = 1'b1;
					m_relay = 1'b0;
				end
				if ((!uses_relay() || !m_relay) && (!uses_burst() || !m_burst)) begin
					m_phase = PH_WAIT;
					m_timer = '0;
				end
			end else if (m_phase == PH_WAIT) begin
				wait_len = 32'(m_cfg.post_wait) + 32'(m_delay);
				if (32'(m_timer) >= wait_len) begin
					if (m_delay >= m_cfg.sweep_end) begin
						end_test(1'b1);
					end else begin
						// delay sweeps upward and sticks at the top
						grown   = 32'(m_delay) + 32'(m_cfg.sweep_step);
						m_delay = (grown > 32'hFFFF) ? 16'hFFFF : grown[DELAY_W-1:0];
						enter_action();
					end
				end
			end
			// timer still counts on the tick a finish lands, it is cleared at next start
			if (m_timer != TIMER_MAX)
				m_timer = m_timer + TIMER_W'(1);
		end

		m_prev = lvl;

		// on and off in the same tick cancel out
		if (f_on && !f_off)
			r.relay_cmd = RLY_ON;
		else if (f_off && !f_on)
			r.relay_cmd = RLY_OFF;
		else
			r.relay_cmd = RLY_NONE;
		r.send_frame    = f_frame;
		r.relay_state   = m_relay;
		r.status_nm3    = m_status[TRIG_NM3];
		r.status_wup    = m_status[TRIG_WUP];
		r.status_both   = m_status[TRIG_BOTH];
		r.current_delay = m_delay;
		r.phase_code    = m_phase;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// clock and run limit
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// far beyond the slowest legal run, only reached when beats stop moving
	initial begin
		#(3_000_000);
		$display("wakeup_sweep_sequencer_unit: mismatch");
		$finish;
	end

	// ------------------------------------------------------------------
	// result sink: random ready, plus one long stall on request
	// ------------------------------------------------------------------
	initial begin
		int unsigned stall_left;
		int unsigned seen_req;
		stall_left   = 0;
		seen_req     = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != seen_req) begin
				seen_req   = hold_requests;
				stall_left = LONG_STALL;
			end
			if (stall_left != 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: predict on every accepted tick beat, check every result beat
	// both in one process so a beat never races its own expectation
	// ------------------------------------------------------------------
	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_PRINTS)
			$display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
	endtask

	always @(posedge clk) begin : result_monitor
		res_t got;
		res_t want;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				tick_results_q.push_back(sequencer_tick({in_ch.trig_both, in_ch.trig_wup,
					in_ch.trig_nm3}));
			if (out_ch.valid && out_ch.ready) begin
				got.send_frame    = out_ch.send_frame;
				got.relay_cmd     = out_ch.relay_cmd;
				got.relay_state   = out_ch.relay_state;
				got.status_nm3    = out_ch.status_nm3;
				got.status_wup    = out_ch.status_wup;
				got.status_both   = out_ch.status_both;
				got.current_delay = out_ch.current_delay;
				got.phase_code    = out_ch.phase_code;
				if (tick_results_q.size() == 0) begin
					report_mismatch("result beat with no tick pending", 1, 0);
				end else begin
					want = tick_results_q.pop_front();
					if (got.send_frame !== want.send_frame)
						report_mismatch("send_frame", got.send_frame, want.send_frame);
					if (got.relay_cmd !== want.relay_cmd)
						report_mismatch("relay_cmd", got.relay_cmd, want.relay_cmd);
					if (got.relay_state !== want.relay_state)
						report_mismatch("relay_state", got.relay_state, want.relay_state);
					if (got.status_nm3 !== want.status_nm3)
						report_mismatch("status_nm3", got.status_nm3, want.status_nm3);
					if (got.status_wup !== want.status_wup)
						report_mismatch("status_wup", got.status_wup, want.status_wup);
					if (got.status_both !== want.status_both)
						report_mismatch("status_both", got.status_both, want.status_both);
					if (got.current_delay !== want.current_delay)
						report_mismatch("current_delay", got.current_delay, want.current_delay);
					if (got.phase_code !== want.phase_code)
						report_mismatch("phase_code", got.phase_code, want.phase_code);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// tick source and register port
	// ------------------------------------------------------------------

	// one tick beat: random gap first, then hold valid until the block takes it;
	// valid is left high so back-to-back beats never toggle it
	task automatic send_tick(trig_t lvl);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.trig_nm3  <= lvl[TRIG_NM3];
		in_ch.trig_wup  <= lvl[TRIG_WUP];
		in_ch.trig_both <= lvl[TRIG_BOTH];
		do
			@(posedge clk);
		while (!in_ch.ready);
		ticks_sent++;
	endtask

	// stop offering ticks and let every owed result come out
	task automatic quiesce();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (tick_results_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_index   <= idx;
		cfg_wr_data <= data;
		@(posedge clk);
		case (idx)
			REG_BURST_PERIOD: m_cfg.burst_period = data[CNT_W-1:0];
			REG_BURST_FRAMES: m_cfg.burst_frames = data[CNT_W-1:0];
			REG_RELAY_HOLD:   m_cfg.relay_hold   = data;
			REG_POST_WAIT:    m_cfg.post_wait    = data;
			REG_SWEEP_START:  m_cfg.sweep_start  = data;
			REG_SWEEP_END:    m_cfg.sweep_end    = data;
			REG_SWEEP_STEP:   m_cfg.sweep_step   = data[CNT_W-1:0];
			default: ;
		endcase
	endtask

	// all registers rewritten while nothing is in flight; byte registers get
	// junk in the upper byte, which the block must drop
	task automatic apply_config(cfg_t c);
		quiesce();
		write_reg(REG_BURST_PERIOD, {8'($urandom_range(0, 255)), c.burst_period});
		write_reg(REG_BURST_FRAMES, {8'($urandom_range(0, 255)), c.burst_frames});
		write_reg(REG_RELAY_HOLD, c.relay_hold);
		write_reg(REG_POST_WAIT, c.post_wait);
		write_reg(REG_SWEEP_START, c.sweep_start);
		write_reg(REG_SWEEP_END, c.sweep_end);
		write_reg(REG_SWEEP_STEP, {8'($urandom_range(0, 255)), c.sweep_step});
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// short sweeps so tests finish within a few hundred ticks; zero values
	// and the odd top value mixed in
	function automatic cfg_t random_small_cfg();
		cfg_t c;
		c.burst_period = CNT_W'($urandom_range(0, 4));
		c.burst_frames = CNT_W'($urandom_range(0, 6));
		c.relay_hold   = DELAY_W'($urandom_range(0, 12));
		c.post_wait    = DELAY_W'($urandom_range(0, 8));
		c.sweep_start  = DELAY_W'($urandom_range(0, 6));
		c.sweep_end    = DELAY_W'($urandom_range(0, 14));
		c.sweep_step   = ($urandom_range(0, 9) == 0) ? '0 : CNT_W'($urandom_range(1, 4));
		if ($urandom_range(0, 9) == 0)
			c.sweep_step = 8'hFF;
		if ($urandom_range(0, 14) == 0)
			c.burst_period = 8'hFF;
		return c;
	endfunction

	// mostly a clean start: levels low, one level raised and held for a while
	// (long enough to finish, or cut short to abort), with now and then stray
	// rises on the other levels; the rest is pure noise
	task automatic run_sweep_sequence();
		trig_t       lvl;
		int unsigned len;
		if ($urandom_range(0, 6) == 0) begin
			repeat ($urandom_range(1, 8))
				send_tick(trig_t'($urandom_range(0, 7)));
		end else begin
			repeat ($urandom_range(1, 2))
				send_tick(3'b000);
			case ($urandom_range(0, 3))
				0:       lvl = 3'b001;
				1:       lvl = 3'b010;
				2:       lvl = 3'b100;
				default: lvl = trig_t'($urandom_range(1, 7));
			endcase
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : $urandom_range(20, 250);
			repeat (len)
				send_tick(($urandom_range(0, 4) == 0) ? (lvl | trig_t'($urandom_range(0, 7)))
					: lvl);
		end
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// hand-picked ticks: start priority, abort with relay held, start above end,
	// no new start without a fresh rise, zero burst period
	task automatic test_directed_cases();
		cfg_t c;
		src_idle_pct   = 20;
		snk_idle_pct   = 30;
		c.burst_period = 8'd0;
		c.burst_frames = 8'd2;
		c.relay_hold   = 16'd2;
		c.post_wait    = 16'd1;
		c.sweep_start  = 16'd3;
		c.sweep_end    = 16'd2;
		c.sweep_step   = 8'hFF;
		apply_config(c);
		send_tick(3'b000);
		// all levels rise together: combined mode wins
		repeat (2)
			send_tick(3'b111);
		// its own level drops while the relay is still held
		send_tick(3'b011);
		send_tick(3'b000);
		// relay-only beats burst-only, one sweep pass then finished
		repeat (8)
			send_tick(3'b011);
		// burst level was already high, no rise, status stays finished
		send_tick(3'b001);
		send_tick(3'b000);
		// burst-only with a zero period, dropped during the wait
		repeat (5)
			send_tick(3'b001);
		send_tick(3'b000);
	endtask

	// every register at its top value, then at zero, then zero step that never ends
	task automatic test_register_extremes();
		cfg_t c;
		src_idle_pct = 30;
		snk_idle_pct = 30;
		c = '1;
		apply_config(c);
		send_tick(3'b000);
		repeat (12)
			send_tick(3'b100);
		send_tick(3'b000);
		// zero frames, zero hold, zero wait: each mode finishes right away
		c = '0;
		apply_config(c);
		repeat (3)
			send_tick(3'b001);
		send_tick(3'b000);
		repeat (3)
			send_tick(3'b010);
		send_tick(3'b000);
		repeat (3)
			send_tick(3'b100);
		send_tick(3'b000);
		// zero step with the end above the start: loops until the level drops
		c.sweep_end = 16'd1;
		apply_config(c);
		repeat (12)
			send_tick(3'b100);
		send_tick(3'b000);
	endtask

	// sink stalls for a long stretch while ticks keep coming, so the block fills
	task automatic test_backpressure_fill();
		apply_config(random_small_cfg());
		src_idle_pct = 0;
		snk_idle_pct = 0;
		hold_requests++;
		send_tick(3'b000);
		repeat (40)
			send_tick(3'b010);
		send_tick(3'b000);
	endtask

	task automatic test_random_sweeps(int unsigned n_ticks, int unsigned src_pct,
		int unsigned snk_pct);
		int unsigned first_tick;
		apply_config(random_small_cfg());
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		first_tick   = ticks_sent;
		while (ticks_sent - first_tick < n_ticks) begin
			if ($urandom_range(0, 3) == 0)
				apply_config(random_small_cfg());
			run_sweep_sequence();
		end
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n          = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.trig_nm3  = 1'b0;
		in_ch.trig_wup  = 1'b0;
		in_ch.trig_both = 1'b0;
		cfg_wr_en       = 1'b0;
		cfg_index       = REG_BURST_PERIOD;
		cfg_wr_data     = '0;
		src_idle_pct    = 0;
		snk_idle_pct    = 0;
		hold_requests   = 0;
		ticks_sent      = 0;
		mismatch_cnt    = 0;

		// model starts from the register reset values and an idle sequencer
		m_cfg.burst_period = RST_BURST_PERIOD;
		m_cfg.burst_frames = RST_BURST_FRAMES;
		m_cfg.relay_hold   = RST_RELAY_HOLD;
		m_cfg.post_wait    = RST_POST_WAIT;
		m_cfg.sweep_start  = RST_SWEEP_START;
		m_cfg.sweep_end    = RST_SWEEP_END;
		m_cfg.sweep_step   = RST_SWEEP_STEP;
		m_mode       = MODE_OFF;
		m_phase      = PH_IDLE;
		m_delay      = '0;
		m_timer      = '0;
		m_next_frame = '0;
		m_frames     = '0;
		m_burst      = 1'b0;
		m_relay      = 1'b0;
		m_prev       = '0;
		foreach (m_status[i])
			m_status[i] = ST_IDLE;

		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_register_extremes();
		test_backpressure_fill();
		test_random_sweeps(370, 35, 54);
		test_random_sweeps(370, 54, 35);
		test_random_sweeps(370, 0, 0);

		// drain, then a few quiet cycles to catch stray result beats
		quiesce();
		repeat (8)
			@(posedge clk);
		if (mismatch_cnt == 0)
			$display("wakeup_sweep_sequencer_unit: match");
		else
			$display("wakeup_sweep_sequencer_unit: mismatch");
		$finish;
	end

endmodule
